@@ rtl/julian_day_to_calendar_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Julian day to calendar converter
// Shared property wrappers; clock and active-low reset are passed in.
// ----------------------------------------------------------------------------
`ifndef JULIAN_DAY_TO_CALENDAR_TOP_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication with the delay given by n, disabled while reset is asserted.
`define JDC_ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

@@ rtl/jdc_pkg.sv @@
// ----------------------------------------------------------------------------
// jdc_pkg
// Widths, reciprocal constants and tables for the Julian day converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jdc_pkg;

    // Input format
    localparam int DAY_BITS      = 22;
    localparam int FRACTION_BITS = 32;
    localparam int JD_W          = DAY_BITS + FRACTION_BITS;
    localparam int Z_W           = DAY_BITS + 1;   // whole day after the half-day carry

    localparam logic [JD_W:0]    HALF_DAY   = (JD_W + 1)'(64'd1 << (FRACTION_BITS - 1));
    localparam logic [Z_W-1:0]   GREG_START = Z_W'(2299161);

    // alpha = (4Z - 7468865) / 146097
    localparam int NA_W      = Z_W + 2;
    localparam int NA_OFFSET = 7468865;
    localparam int AL_DIV    = 146097;
    localparam int AL_SHIFT  = NA_W + 18;
    localparam longint unsigned AL_MUL =
        ((64'd1 << AL_SHIFT) + 64'(AL_DIV) - 64'd1) / 64'(AL_DIV);
    localparam int AL_MUL_W  = $clog2(AL_MUL + 64'd1);
    localparam int AL_W      = Z_W - 15;
    localparam logic [AL_MUL_W-1:0] AL_MUL_V = AL_MUL_W'(AL_MUL);

    // B = A + 1524
    localparam int B_W      = Z_W + 1;
    localparam int B_OFFSET = 1524;

    // C = (20B - 2442) / 7305
    localparam int NC_W      = B_W + 5;
    localparam int NC_OFFSET = 2442;
    localparam int C_DIV     = 7305;
    localparam int C_SHIFT   = NC_W + 13;
    localparam longint unsigned C_MUL =
        ((64'd1 << C_SHIFT) + 64'(C_DIV) - 64'd1) / 64'(C_DIV);
    localparam int C_MUL_W   = $clog2(C_MUL + 64'd1);
    localparam int C_W       = NC_W - 12;
    localparam logic [C_MUL_W-1:0] C_MUL_V = C_MUL_W'(C_MUL);

    // D = 1461C / 4; B - D always lies below 2^X_W
    localparam int D_MUL    = 1461;
    localparam int D_PROD_W = C_W + 11;
    localparam int X_W      = 9;

    // E = 10000(B - D) / 306001, scale folded into the reciprocal
    localparam int E_SCALE  = 10000;
    localparam int E_DIV    = 306001;
    localparam int E_SHIFT  = X_W + 14 + 19;
    localparam longint unsigned E_MUL =
        64'(E_SCALE) * (((64'd1 << E_SHIFT) + 64'(E_DIV) - 64'd1) / 64'(E_DIV));
    localparam int E_MUL_W  = $clog2(E_MUL + 64'd1);
    localparam int E_W      = 5;
    localparam logic [E_MUL_W-1:0] E_MUL_V = E_MUL_W'(E_MUL);

    localparam int MONTH_WRAP_E   = 14;
    localparam int MONTH_LOW_OFF  = 1;
    localparam int MONTH_HIGH_OFF = 13;
    localparam int LAST_WINTER    = 2;          // February
    localparam int YEAR_OFF_LATE  = 4716;
    localparam int YEAR_OFF_EARLY = 4715;

    // Output fields
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Time of day
    localparam int SECS_W      = 17;
    localparam int SEC_PER_DAY = 86400;
    localparam int SEC_PER_MIN = 60;
    localparam int H_DIV       = 3600;
    localparam int H_SHIFT     = SECS_W + 12;
    localparam longint unsigned H_MUL =
        ((64'd1 << H_SHIFT) + 64'(H_DIV) - 64'd1) / 64'(H_DIV);
    localparam int H_MUL_W     = $clog2(H_MUL + 64'd1);
    localparam logic [H_MUL_W-1:0] H_MUL_V = H_MUL_W'(H_MUL);
    localparam int M_SHIFT     = SECS_W + 6;
    localparam longint unsigned M_MUL =
        ((64'd1 << M_SHIFT) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);
    localparam int M_MUL_W     = $clog2(M_MUL + 64'd1);
    localparam logic [M_MUL_W-1:0] M_MUL_V = M_MUL_W'(M_MUL);
    localparam int MINS_W      = 11;            // minutes of the day, below 1440

    localparam int PIPE_DEPTH = 8;

    typedef logic [X_W-1:0] t_day_count;

    // floor(30.6001 * e): days before the month that E stands for
    function automatic t_day_count month_offset(input logic [E_W-1:0] e);
        t_day_count v;
        unique case (e)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/julian_day_to_calendar_top.sv @@
// ----------------------------------------------------------------------------
// julian_day_to_calendar_top
// Julian day (fixed point) to calendar date and time of day, Meeus method.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge with start high and busy low; busy
// is high only while reset is held, so one timestamp can enter per cycle. The
// result appears on the o_ ports with o_done high for one cycle, once it has
// passed the eight register stages of the pipeline around the constant-reciprocal
// multipliers. The output side cannot stall, so results must be captured when
// o_done is high. Days below 2299161 follow the Julian calendar, later days the
// Gregorian one; years out of range wrap to 14 bits without a flag.
`timescale 1ns / 1ps
`default_nettype none
`include "julian_day_to_calendar_top_macros.svh"

module julian_day_to_calendar_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [jdc_pkg::JD_W-1:0]              i_julian_day_fixed,
    output logic                                       o_done,
    output logic signed [jdc_pkg::YEAR_W-1:0]          o_year,
    output logic [jdc_pkg::MONTH_W-1:0]                o_month,
    output logic [jdc_pkg::DAY_W-1:0]                  o_day_of_month,
    output logic [jdc_pkg::HOUR_W-1:0]                 o_hour,
    output logic [jdc_pkg::MIN_W-1:0]                  o_minute,
    output logic [jdc_pkg::SEC_W-1:0]                  o_second
);

    // ---------------- control ----------------
    logic                            r_busy;
    logic [jdc_pkg::PIPE_DEPTH-1:0]  r_vld;
    logic [jdc_pkg::PIPE_DEPTH-1:0]  n_vld;
    logic                            w_accept;

    assign w_accept = start & ~r_busy;
    assign n_vld    = {r_vld[jdc_pkg::PIPE_DEPTH-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= n_vld;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_vld[jdc_pkg::PIPE_DEPTH-1];

    // ---------------- stage 1: half-day carry, split Z and F ----------------
    logic [jdc_pkg::JD_W:0]             w_shifted;
    logic [jdc_pkg::Z_W-1:0]            n_s1_z;
    logic [jdc_pkg::NA_W-1:0]           n_s1_na;
    logic [jdc_pkg::Z_W-1:0]            r_s1_z;
    logic [jdc_pkg::FRACTION_BITS-1:0]  r_s1_f;
    logic                               r_s1_greg;
    logic [jdc_pkg::NA_W-1:0]           r_s1_na;

    assign w_shifted = {1'b0, i_julian_day_fixed} + jdc_pkg::HALF_DAY;
    assign n_s1_z    = w_shifted[jdc_pkg::JD_W -: jdc_pkg::Z_W];
    // only meaningful on the Gregorian side, where it cannot go negative
    assign n_s1_na   = {n_s1_z, 2'b00} - jdc_pkg::NA_W'(jdc_pkg::NA_OFFSET);

    always_ff @(posedge i_clk) begin
        r_s1_z    <= n_s1_z;
        r_s1_f    <= w_shifted[jdc_pkg::FRACTION_BITS-1:0];
        r_s1_greg <= (n_s1_z >= jdc_pkg::GREG_START);
        r_s1_na   <= n_s1_na;
    end

    // ---------------- stage 2: alpha and seconds of day ----------------
    logic [jdc_pkg::NA_W+jdc_pkg::AL_MUL_W-1:0]   w_al_prod;
    logic [jdc_pkg::FRACTION_BITS+16:0]           w_sec_prod;
    logic [jdc_pkg::Z_W-1:0]                      r_s2_z;
    logic                                         r_s2_greg;
    logic [jdc_pkg::AL_W-1:0]                     r_s2_alpha;
    logic [jdc_pkg::SECS_W-1:0]                   r_s2_secs;

    assign w_al_prod  = (jdc_pkg::NA_W + jdc_pkg::AL_MUL_W)'(r_s1_na)
                      * (jdc_pkg::NA_W + jdc_pkg::AL_MUL_W)'(jdc_pkg::AL_MUL_V);
    assign w_sec_prod = (jdc_pkg::FRACTION_BITS + 17)'(r_s1_f)
                      * (jdc_pkg::FRACTION_BITS + 17)'(jdc_pkg::SEC_PER_DAY);

    always_ff @(posedge i_clk) begin
        r_s2_z     <= r_s1_z;
        r_s2_greg  <= r_s1_greg;
        r_s2_alpha <= w_al_prod[jdc_pkg::AL_SHIFT +: jdc_pkg::AL_W];
        r_s2_secs  <= w_sec_prod[jdc_pkg::FRACTION_BITS +: jdc_pkg::SECS_W];
    end

    // ---------------- stage 3: B, hour and minute of day ----------------
    logic [jdc_pkg::B_W-1:0]                      w_greg_adj;
    logic [jdc_pkg::SECS_W+jdc_pkg::H_MUL_W-1:0]  w_h_prod;
    logic [jdc_pkg::SECS_W+jdc_pkg::M_MUL_W-1:0]  w_m_prod;
    logic [jdc_pkg::B_W-1:0]                      r_s3_b;
    logic [jdc_pkg::HOUR_W-1:0]                   r_s3_hour;
    logic [jdc_pkg::MINS_W-1:0]                   r_s3_mins;
    logic [jdc_pkg::SECS_W-1:0]                   r_s3_secs;

    assign w_greg_adj = r_s2_greg
        ? (jdc_pkg::B_W'(r_s2_alpha) - jdc_pkg::B_W'(r_s2_alpha >> 2) + jdc_pkg::B_W'(1))
        : '0;
    assign w_h_prod = (jdc_pkg::SECS_W + jdc_pkg::H_MUL_W)'(r_s2_secs)
                    * (jdc_pkg::SECS_W + jdc_pkg::H_MUL_W)'(jdc_pkg::H_MUL_V);
    assign w_m_prod = (jdc_pkg::SECS_W + jdc_pkg::M_MUL_W)'(r_s2_secs)
                    * (jdc_pkg::SECS_W + jdc_pkg::M_MUL_W)'(jdc_pkg::M_MUL_V);

    always_ff @(posedge i_clk) begin
        r_s3_b    <= jdc_pkg::B_W'(r_s2_z) + w_greg_adj + jdc_pkg::B_W'(jdc_pkg::B_OFFSET);
        r_s3_hour <= w_h_prod[jdc_pkg::H_SHIFT +: jdc_pkg::HOUR_W];
        r_s3_mins <= w_m_prod[jdc_pkg::M_SHIFT +: jdc_pkg::MINS_W];
        r_s3_secs <= r_s2_secs;
    end

    // ---------------- stage 4: C numerator, minute and second ----------------
    logic [jdc_pkg::MINS_W-1:0]   w_hour60;
    logic [jdc_pkg::SECS_W-1:0]   w_min60;
    logic [jdc_pkg::NC_W-1:0]     r_s4_nc;
    logic [jdc_pkg::B_W-1:0]      r_s4_b;
    logic [jdc_pkg::HOUR_W-1:0]   r_s4_hour;
    logic [jdc_pkg::MIN_W-1:0]    r_s4_minute;
    logic [jdc_pkg::SEC_W-1:0]    r_s4_second;

    assign w_hour60 = jdc_pkg::MINS_W'(r_s3_hour) * jdc_pkg::MINS_W'(jdc_pkg::SEC_PER_MIN);
    assign w_min60  = jdc_pkg::SECS_W'(r_s3_mins) * jdc_pkg::SECS_W'(jdc_pkg::SEC_PER_MIN);

    always_ff @(posedge i_clk) begin
        r_s4_nc     <= jdc_pkg::NC_W'({r_s3_b, 4'b0000}) + jdc_pkg::NC_W'({r_s3_b, 2'b00})
                     - jdc_pkg::NC_W'(jdc_pkg::NC_OFFSET);
        r_s4_b      <= r_s3_b;
        r_s4_hour   <= r_s3_hour;
        r_s4_minute <= r_s3_mins[jdc_pkg::MIN_W-1:0] - w_hour60[jdc_pkg::MIN_W-1:0];
        r_s4_second <= r_s3_secs[jdc_pkg::SEC_W-1:0] - w_min60[jdc_pkg::SEC_W-1:0];
    end

    // ---------------- stage 5: C ----------------
    logic [jdc_pkg::NC_W+jdc_pkg::C_MUL_W-1:0]  w_c_prod;
    logic [jdc_pkg::C_W-1:0]                    r_s5_c;
    logic [jdc_pkg::B_W-1:0]                    r_s5_b;
    logic [jdc_pkg::HOUR_W-1:0]                 r_s5_hour;
    logic [jdc_pkg::MIN_W-1:0]                  r_s5_minute;
    logic [jdc_pkg::SEC_W-1:0]                  r_s5_second;

    assign w_c_prod = (jdc_pkg::NC_W + jdc_pkg::C_MUL_W)'(r_s4_nc)
                    * (jdc_pkg::NC_W + jdc_pkg::C_MUL_W)'(jdc_pkg::C_MUL_V);

    always_ff @(posedge i_clk) begin
        r_s5_c      <= w_c_prod[jdc_pkg::C_SHIFT +: jdc_pkg::C_W];
        r_s5_b      <= r_s4_b;
        r_s5_hour   <= r_s4_hour;
        r_s5_minute <= r_s4_minute;
        r_s5_second <= r_s4_second;
    end

    // ---------------- stage 6: day count within the Meeus year, B - D ----------------
    logic [jdc_pkg::D_PROD_W-1:0]  w_d_prod;
    logic [jdc_pkg::X_W-1:0]       r_s6_x;
    logic [jdc_pkg::C_W-1:0]       r_s6_c;
    logic [jdc_pkg::HOUR_W-1:0]    r_s6_hour;
    logic [jdc_pkg::MIN_W-1:0]     r_s6_minute;
    logic [jdc_pkg::SEC_W-1:0]     r_s6_second;

    assign w_d_prod = jdc_pkg::D_PROD_W'(r_s5_c) * jdc_pkg::D_PROD_W'(jdc_pkg::D_MUL);

    always_ff @(posedge i_clk) begin
        // B - D is below 2^X_W, so the low bits of each side suffice
        r_s6_x      <= r_s5_b[jdc_pkg::X_W-1:0] - w_d_prod[2 +: jdc_pkg::X_W];
        r_s6_c      <= r_s5_c;
        r_s6_hour   <= r_s5_hour;
        r_s6_minute <= r_s5_minute;
        r_s6_second <= r_s5_second;
    end

    // ---------------- stage 7: E ----------------
    logic [jdc_pkg::X_W+jdc_pkg::E_MUL_W-1:0]  w_e_prod;
    logic [jdc_pkg::E_W-1:0]                   r_s7_e;
    logic [jdc_pkg::X_W-1:0]                   r_s7_x;
    logic [jdc_pkg::C_W-1:0]                   r_s7_c;
    logic [jdc_pkg::HOUR_W-1:0]                r_s7_hour;
    logic [jdc_pkg::MIN_W-1:0]                 r_s7_minute;
    logic [jdc_pkg::SEC_W-1:0]                 r_s7_second;

    assign w_e_prod = (jdc_pkg::X_W + jdc_pkg::E_MUL_W)'(r_s6_x)
                    * (jdc_pkg::X_W + jdc_pkg::E_MUL_W)'(jdc_pkg::E_MUL_V);

    always_ff @(posedge i_clk) begin
        r_s7_e      <= w_e_prod[jdc_pkg::E_SHIFT +: jdc_pkg::E_W];
        r_s7_x      <= r_s6_x;
        r_s7_c      <= r_s6_c;
        r_s7_hour   <= r_s6_hour;
        r_s7_minute <= r_s6_minute;
        r_s7_second <= r_s6_second;
    end

    // ---------------- stage 8: day, month, year ----------------
    logic [jdc_pkg::X_W-1:0]      w_day_full;
    logic [jdc_pkg::E_W-1:0]      w_month_full;
    logic [jdc_pkg::MONTH_W-1:0]  n_month;
    logic [jdc_pkg::YEAR_W-1:0]   n_year;
    logic [jdc_pkg::YEAR_W-1:0]   r_year;
    logic [jdc_pkg::MONTH_W-1:0]  r_month;
    logic [jdc_pkg::DAY_W-1:0]    r_day;
    logic [jdc_pkg::HOUR_W-1:0]   r_hour;
    logic [jdc_pkg::MIN_W-1:0]    r_minute;
    logic [jdc_pkg::SEC_W-1:0]    r_second;

    assign w_day_full   = r_s7_x - jdc_pkg::month_offset(r_s7_e);
    assign w_month_full = (r_s7_e < jdc_pkg::E_W'(jdc_pkg::MONTH_WRAP_E))
                        ? r_s7_e - jdc_pkg::E_W'(jdc_pkg::MONTH_LOW_OFF)
                        : r_s7_e - jdc_pkg::E_W'(jdc_pkg::MONTH_HIGH_OFF);
    assign n_month      = w_month_full[jdc_pkg::MONTH_W-1:0];
    // March onward belongs to the year that started with C - 4716
    assign n_year = (n_month > jdc_pkg::MONTH_W'(jdc_pkg::LAST_WINTER))
        ? r_s7_c[jdc_pkg::YEAR_W-1:0] - jdc_pkg::YEAR_W'(jdc_pkg::YEAR_OFF_LATE)
        : r_s7_c[jdc_pkg::YEAR_W-1:0] - jdc_pkg::YEAR_W'(jdc_pkg::YEAR_OFF_EARLY);

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= w_day_full[jdc_pkg::DAY_W-1:0];
        r_hour   <= r_s7_hour;
        r_minute <= r_s7_minute;
        r_second <= r_s7_second;
    end

    assign o_year         = signed'(r_year);
    assign o_month        = r_month;
    assign o_day_of_month = r_day;
    assign o_hour         = r_hour;
    assign o_minute       = r_minute;
    assign o_second       = r_second;

    // ---------------- assertions ----------------
    `JDC_ASSERT_AFTER(a_latency, i_clk, i_rst_n, start && !busy, jdc_pkg::PIPE_DEPTH, o_done, "result strobe missing after transaction")
    `JDC_ASSERT_IMPL(a_month_range, i_clk, i_rst_n, o_done, o_month >= 4'd1 && o_month <= 4'd12, "month out of range")
    `JDC_ASSERT_IMPL(a_day_range, i_clk, i_rst_n, o_done, o_day_of_month >= 5'd1 && o_day_of_month <= 5'd31, "day out of range")
    `JDC_ASSERT_IMPL(a_time_range, i_clk, i_rst_n, o_done, o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59, "time of day out of range")

endmodule

`default_nettype wire
